// ===== sv/minimal_standard_random_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Minimal standard random generator - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MINIMAL_STANDARD_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define MINIMAL_STANDARD_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MSRG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msrg_pkg.sv =====
// ----------------------------------------------------------------------------
// msrg_pkg
// Constants, payload types and state encodings of the random generator.
// ----------------------------------------------------------------------------
package msrg_pkg;

    localparam int MAX_BYTES = 64;
    localparam int CNT_W     = 7;

    // input mode codes
    localparam logic MODE_INT   = 1'b0;
    localparam logic MODE_BYTES = 1'b1;

    // APB register map: index sits at paddr[REG_IDX_LSB]
    localparam int   PADDR_W     = 3;
    localparam int   DATA_W      = 32;
    localparam int   REG_IDX_LSB = 2;
    localparam logic REG_SEED    = 1'b0;

    // Park-Miller / Schrage constants
    localparam logic [31:0] PM_MASK = 32'd123459876;
    localparam logic [14:0] PM_MUL  = 15'd16807;
    localparam logic [30:0] PM_MOD  = 31'd2147483647;
    localparam logic [16:0] PM_Q    = 17'd127773;
    localparam logic [11:0] PM_R    = 12'd2836;

    // quotient by PM_Q via reciprocal; estimate is exact or one low
    localparam int          RECIP_SHIFT = 48;
    localparam int          K0_W        = 64 - RECIP_SHIFT;
    localparam logic [31:0] RECIP_M     = 32'((64'd1 << RECIP_SHIFT) / 64'(PM_Q));

    // queue sizes
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 1 << CMDQ_AW;
    localparam int CMDQ_CW    = CMDQ_AW + 1;
    localparam int OUTQ_AW    = 1;
    localparam int OUTQ_DEPTH = 1 << OUTQ_AW;
    localparam int OUTQ_CW    = OUTQ_AW + 1;

    // byte slot of the last byte taken from one step
    localparam logic [1:0] LAST_POS = 2'd2;

    typedef struct packed {
        logic             is_int;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic [30:0] int_value;
        logic [7:0]  byte_value;
        logic        last;
    } t_res;

    typedef struct packed {
        logic        start;
        logic [31:0] word;
    } t_step_req;

    typedef struct packed {
        logic        done;
        logic [31:0] word;
    } t_step_rsp;

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_RECIP,
        SU_REM,
        SU_PROD,
        SU_FIN
    } t_su_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STEP,
        BK_EMIT
    } t_bk_state;

endpackage

// ===== sv/msrg_front.sv =====
// ----------------------------------------------------------------------------
// msrg_front
// Accepts request words, drops empty byte runs, saturates the byte count and
// queues commands for the back end.
// ----------------------------------------------------------------------------
module msrg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_mode,
    input  logic [msrg_pkg::CNT_W-1:0] i_byte_count,
    output logic                       o_cmd_valid,
    output msrg_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_pop
);
    import msrg_pkg::*;

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wptr;
    logic [CMDQ_AW-1:0] r_rptr;
    logic [CMDQ_CW-1:0] r_cnt;

    logic keep;
    logic wr;
    logic rd;
    t_cmd cmd_in;

    always_comb begin
        keep          = (i_mode == MODE_INT) || (i_byte_count != '0);
        cmd_in.is_int = (i_mode == MODE_INT);
        cmd_in.count  = (i_byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES)
                                                           : i_byte_count;
    end

    assign o_full      = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign wr          = i_push && !o_full && keep;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + CMDQ_AW'(1);
            end
            if (rd) begin
                r_rptr <= r_rptr + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(wr) - CMDQ_CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

// ===== sv/msrg_step.sv =====
// ----------------------------------------------------------------------------
// msrg_step
// One generator step: mask, Schrage split by reciprocal multiply, products,
// signed difference with one modulus fold, mask again.
// ----------------------------------------------------------------------------
module msrg_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msrg_pkg::t_step_req i_req,
    output msrg_pkg::t_step_rsp o_rsp
);
    import msrg_pkg::*;

    t_su_state r_state;
    t_su_state n_state;
    logic      r_done;

    logic [31:0] r_a;       // |v|
    logic        r_neg;     // sign of v
    logic [63:0] r_prod;    // |v| * reciprocal
    logic [14:0] r_k;
    logic [16:0] r_r;
    logic [31:0] r_p1;      // 16807 * r
    logic [25:0] r_p2;      // 2836 * k
    logic [31:0] r_word_out;

    logic [31:0]     v;
    logic [31:0]     v_abs;
    logic [K0_W-1:0] k0;
    logic [32:0]     kq;
    logic [32:0]     rem0;
    logic            ge;
    logic [14:0]     k_fix;
    logic [16:0]     r_fix;
    logic [32:0]     diff;
    logic [32:0]     fold;

    always_comb begin
        v     = i_req.word ^ PM_MASK;
        v_abs = v[31] ? (~v + 32'd1) : v;

        k0    = r_prod[63:RECIP_SHIFT];
        kq    = 33'(k0) * 33'(PM_Q);
        rem0  = {1'b0, r_a} - kq;
        ge    = (rem0 >= 33'(PM_Q));
        k_fix = ge ? 15'(k0 + K0_W'(1)) : 15'(k0);
        r_fix = ge ? 17'(rem0 - 33'(PM_Q)) : 17'(rem0);

        // negative input flips the sign of the whole difference
        diff = r_neg ? (33'(r_p2) - 33'(r_p1)) : (33'(r_p1) - 33'(r_p2));
        fold = diff[32] ? (diff + 33'(PM_MOD)) : diff;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SU_IDLE: begin
                if (i_req.start) begin
                    n_state = SU_RECIP;
                end
            end
            SU_RECIP: n_state = SU_REM;
            SU_REM:   n_state = SU_PROD;
            SU_PROD:  n_state = SU_FIN;
            SU_FIN:   n_state = SU_IDLE;
            default:  n_state = SU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SU_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SU_IDLE && i_req.start) begin
            r_a   <= v_abs;
            r_neg <= v[31];
        end
        if (r_state == SU_RECIP) begin
            r_prod <= 64'(r_a) * 64'(RECIP_M);
        end
        if (r_state == SU_REM) begin
            r_k <= k_fix;
            r_r <= r_fix;
        end
        if (r_state == SU_PROD) begin
            r_p1 <= 32'(r_r) * 32'(PM_MUL);
            r_p2 <= 26'(r_k) * 26'(PM_R);
        end
        if (r_state == SU_FIN) begin
            r_word_out <= fold[31:0] ^ PM_MASK;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.word = r_word_out;

endmodule

// ===== sv/msrg_back.sv =====
// ----------------------------------------------------------------------------
// msrg_back
// Sequencer: owns the generator word, runs steps and splits them into
// result words (one integer, or up to three bytes per step).
// ----------------------------------------------------------------------------
module msrg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  msrg_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_seed_wr,
    input  logic [31:0]         i_seed,
    output msrg_pkg::t_step_req o_step_req,
    input  msrg_pkg::t_step_rsp i_step_rsp,
    output logic                o_res_push,
    output msrg_pkg::t_res      o_res,
    input  logic                i_res_full
);
    import msrg_pkg::*;

    t_bk_state        r_state;
    t_bk_state        n_state;
    logic [31:0]      r_word;
    logic [30:0]      r_gen;
    logic             r_is_int;
    logic [CNT_W-1:0] r_left;
    logic [1:0]       r_pos;

    logic       step_start;
    logic       last_byte;
    logic [7:0] byte_sel;

    always_comb begin
        last_byte = (r_left == CNT_W'(1));
        unique case (r_pos)
            2'd0:    byte_sel = r_gen[7:0];
            2'd1:    byte_sel = r_gen[15:8];
            default: byte_sel = r_gen[23:16];
        endcase
        if (r_is_int) begin
            o_res.int_value  = r_gen;
            o_res.byte_value = '0;
            o_res.last       = 1'b1;
        end else begin
            o_res.int_value  = '0;
            o_res.byte_value = byte_sel;
            o_res.last       = last_byte;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        step_start = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    step_start = 1'b1;
                    n_state    = BK_STEP;
                end
            end
            BK_STEP: begin
                if (i_step_rsp.done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_is_int || last_byte) begin
                        n_state = BK_IDLE;
                    end else if (r_pos == LAST_POS) begin
                        step_start = 1'b1;
                        n_state    = BK_STEP;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_step_req.start = step_start;
    assign o_step_req.word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_word   <= '0;
            r_is_int <= 1'b0;
            r_left   <= '0;
            r_pos    <= '0;
        end else begin
            r_state <= n_state;
            if (i_seed_wr) begin
                r_word <= i_seed;
            end else if (r_state == BK_STEP && i_step_rsp.done) begin
                r_word <= i_step_rsp.word;
            end
            if (o_cmd_pop) begin
                r_is_int <= i_cmd.is_int;
                r_left   <= i_cmd.count;
            end
            if (r_state == BK_STEP && i_step_rsp.done) begin
                r_pos <= '0;
            end else if (o_res_push && !r_is_int) begin
                r_pos  <= r_pos + 2'd1;
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_STEP && i_step_rsp.done) begin
            r_gen <= i_step_rsp.word[30:0];
        end
    end

endmodule

// ===== sv/msrg_outq.sv =====
// ----------------------------------------------------------------------------
// msrg_outq
// Two-entry result queue; decouples the sequencer from the consumer.
// ----------------------------------------------------------------------------
module msrg_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msrg_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_empty,
    output msrg_pkg::t_res o_res,
    input  logic           i_pop
);
    import msrg_pkg::*;

    t_res               r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wptr;
    logic [OUTQ_AW-1:0] r_rptr;
    logic [OUTQ_CW-1:0] r_cnt;

    logic wr;
    logic rd;

    assign o_full  = (r_cnt == OUTQ_CW'(OUTQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + OUTQ_AW'(1);
            end
            if (rd) begin
                r_rptr <= r_rptr + OUTQ_AW'(1);
            end
            r_cnt <= r_cnt + OUTQ_CW'(wr) - OUTQ_CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

// ===== sv/minimal_standard_random_generator_unit.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_random_generator_unit
// Park-Miller minimal standard generator (16807 mod 2^31-1, Schrage split)
// with a fixed XOR mask, serving single integers or runs of bytes.
//
// Request side: push/full. Each word carries i_mode (0 = one 31-bit integer,
//   1 = a run of bytes) and i_byte_count (1..64, larger counts clip to 64,
//   zero in byte mode yields nothing). Requests go to a 2-deep command queue.
// Result side: empty/pop. Integer results set o_last; byte runs give one
//   word per byte, least significant byte of each step first, o_last on the
//   final byte. Results sit in a 2-deep queue.
// APB: one register, seed, at offset 0x0. Writing it reloads the generator.
//   Reads return the seed register. pready is tied high.
// Sequencing: a step passes through the step unit states RECIP, REM, PROD and
//   FIN. The sequencer serves one request at a time; in a byte run it starts
//   the next step only after the bytes of the current step are emitted.
// Stall: when the consumer holds off pop, the result queue fills, the
//   sequencer waits, the command queue fills and full rises.
// Reset (synchronous, active low) empties both queues and clears the seed
//   register and the generator word to zero.
// ----------------------------------------------------------------------------
`include "minimal_standard_random_generator_unit_defines.svh"

module minimal_standard_random_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request queue side
    input  logic                         push,
    output logic                         full,
    input  logic                         i_mode,
    input  logic [msrg_pkg::CNT_W-1:0]   i_byte_count,
    // result queue side
    output logic                         empty,
    input  logic                         pop,
    output logic [30:0]                  o_int_value,
    output logic [7:0]                   o_byte_value,
    output logic                         o_last,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msrg_pkg::PADDR_W-1:0] paddr,
    input  logic [msrg_pkg::DATA_W-1:0]  pwdata,
    output logic [msrg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import msrg_pkg::*;

    logic [DATA_W-1:0] r_seed;
    logic              seed_wr;

    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_pop;
    t_step_req step_req;
    t_step_rsp step_rsp;
    logic      res_push;
    t_res      res_in;
    logic      res_full;
    t_res      res_out;

    // APB: no wait states (pready tied high), register selected by one address bit
    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && pready
                     && (paddr[REG_IDX_LSB] == REG_SEED);
    assign prdata  = (paddr[REG_IDX_LSB] == REG_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (seed_wr) begin
            r_seed <= pwdata;
        end
    end

    // front end: accept, classify, queue
    msrg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_byte_count (i_byte_count),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // back end: sequencer plus shared step unit
    msrg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_seed_wr   (seed_wr),
        .i_seed      (pwdata),
        .o_step_req  (step_req),
        .i_step_rsp  (step_rsp),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    msrg_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (step_req),
        .o_rsp   (step_rsp)
    );

    // result queue
    msrg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (res_out),
        .i_pop   (pop)
    );

    assign o_int_value  = res_out.int_value;
    assign o_byte_value = res_out.byte_value;
    assign o_last       = res_out.last;

    // integer words carry no byte and byte words carry no integer
    `MSRG_ASSERT_IMPLY(a_one_kind, !empty, ~|o_int_value || ~|o_byte_value, "mixed int/byte word")
    // an integer result always closes its request
    `MSRG_ASSERT_IMPLY(a_int_last, !empty && (o_int_value != '0), o_last, "no last on int")
    // masked step output stays below 2^31
    `MSRG_ASSERT_IMPLY(a_step_range, step_rsp.done, !step_rsp.word[31], "step out of range")
    // step completion is a single-cycle pulse
    `MSRG_ASSERT_NEXT(a_done_pulse, step_rsp.done, !step_rsp.done, "done held")

endmodule
